FILE: rtl/ofdmdf_pkg.sv
// Package for the OFDM packet deframer: item structs, frame modes, header constants.
// No dependencies; used by every module in rtl/.
package ofdmdf_pkg;

    localparam int unsigned HdrBytes   = 4;
    localparam int unsigned HdrCntW    = $clog2(HdrBytes);
    localparam int unsigned HdrHoldW   = 8 * (HdrBytes - 1);
    localparam int unsigned LenW       = 12;
    localparam int unsigned OffW       = 4;

    localparam logic CMD_BOUNDARY = 1'b0;
    localparam logic CMD_BYTE     = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEARCH  = 2'd0,
        MODE_ARMED   = 2'd1,
        MODE_HEADER  = 2'd2,
        MODE_PAYLOAD = 2'd3
    } frame_mode_t;

    typedef struct packed {
        logic       command;
        logic       sync_flag;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]      payload_byte;
        logic            last;
        logic            empty_packet;
        logic [OffW-1:0] whitener_offset;
        logic [LenW-1:0] packet_length;
        logic            header_error;
    } out_item_t;

endpackage

FILE: rtl/ofdmdf_core.sv
// Deframer state machine: sync arming, header capture and check, payload count.
// Depends on ofdmdf_pkg.
module ofdmdf_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ofdmdf_pkg::in_item_t item,
    output logic                 res_valid,
    output ofdmdf_pkg::out_item_t res
);

    ofdmdf_pkg::frame_mode_t                 mode_reg, mode_next;
    logic [ofdmdf_pkg::HdrHoldW-1:0]         shift_reg, shift_next;
    logic [ofdmdf_pkg::HdrCntW-1:0]          hcnt_reg, hcnt_next;
    logic [ofdmdf_pkg::LenW-1:0]             len_reg, len_next;
    logic [ofdmdf_pkg::LenW-1:0]             seen_reg, seen_next;
    logic [ofdmdf_pkg::OffW-1:0]             off_reg, off_next;
    logic [8*ofdmdf_pkg::HdrBytes-1:0]       hdr_word;
    logic [ofdmdf_pkg::LenW-1:0]             seen_inc;
    logic [ofdmdf_pkg::LenW-1:0]             hdr_len;

    assign hdr_word = {shift_reg, item.data_byte};
    assign hdr_len  = hdr_word[16 +: ofdmdf_pkg::LenW];
    assign seen_inc = seen_reg + ofdmdf_pkg::LenW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ofdmdf_pkg::MODE_SEARCH;
            shift_reg <= '0;
            hcnt_reg  <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
            off_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            shift_reg <= shift_next;
            hcnt_reg  <= hcnt_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            off_reg   <= off_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        shift_next = shift_reg;
        hcnt_next  = hcnt_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        off_next   = off_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (item.command == ofdmdf_pkg::CMD_BOUNDARY)
        begin
            unique case (mode_reg) inside
                ofdmdf_pkg::MODE_SEARCH:
                begin
                    if (item.sync_flag)
                    begin
                        mode_next  = ofdmdf_pkg::MODE_ARMED;
                        shift_next = '0;
                        hcnt_next  = '0;
                    end
                end
                ofdmdf_pkg::MODE_ARMED:   mode_next = ofdmdf_pkg::MODE_HEADER;
                ofdmdf_pkg::MODE_HEADER,
                ofdmdf_pkg::MODE_PAYLOAD: ;
                default: ;
            endcase
        end
        else
        begin
            unique case (mode_reg) inside
                ofdmdf_pkg::MODE_HEADER:
                begin
                    shift_next = hdr_word[ofdmdf_pkg::HdrHoldW-1:0];
                    hcnt_next  = hcnt_reg + ofdmdf_pkg::HdrCntW'(1);
                    if (hcnt_reg == ofdmdf_pkg::HdrCntW'(ofdmdf_pkg::HdrBytes - 1))
                    begin
                        hcnt_next = '0;
                        res_valid = 1'b1;
                        if (hdr_word[31:16] != hdr_word[15:0])
                        begin
                            mode_next        = ofdmdf_pkg::MODE_SEARCH;
                            res.header_error = 1'b1;
                        end
                        else
                        begin
                            len_next  = hdr_len;
                            off_next  = hdr_word[31:28];
                            seen_next = '0;
                            if (hdr_len == '0)
                            begin
                                mode_next           = ofdmdf_pkg::MODE_SEARCH;
                                res.last            = 1'b1;
                                res.empty_packet    = 1'b1;
                                res.whitener_offset = hdr_word[31:28];
                            end
                            else
                            begin
                                mode_next = ofdmdf_pkg::MODE_PAYLOAD;
                                res_valid = 1'b0;
                            end
                        end
                    end
                end
                ofdmdf_pkg::MODE_PAYLOAD:
                begin
                    seen_next           = seen_inc;
                    res_valid           = 1'b1;
                    res.payload_byte    = item.data_byte;
                    res.last            = (seen_inc == len_reg);
                    res.whitener_offset = off_reg;
                    res.packet_length   = len_reg;
                    if (seen_inc == len_reg)
                        mode_next = ofdmdf_pkg::MODE_SEARCH;
                end
                ofdmdf_pkg::MODE_SEARCH,
                ofdmdf_pkg::MODE_ARMED: ;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/ofdmdf_out_reg.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on ofdmdf_pkg.
module ofdmdf_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  load_valid,
    input  ofdmdf_pkg::out_item_t load_item,
    output logic                  space,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ofdmdf_pkg::out_item_t result
);

    logic                  valid_reg;
    ofdmdf_pkg::out_item_t item_reg;

    assign space        = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= load_valid;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            item_reg <= load_item;
    end

endmodule

FILE: rtl/ofdm_packet_deframer.sv
// Top level of the OFDM packet deframer: input register, core, result register.
// Depends on ofdmdf_pkg, ofdmdf_core and ofdmdf_out_reg.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries symbol-boundary markers
//   (command 0, with sync_flag) and demapped bytes (command 1, with data_byte).
//   result channel (result_valid/result_ready/result) carries payload bytes
//   with last, one empty marker for a zero-length header, or a header error.
//   A transfer on the item channel lands in the input register; once the
//   result register has room, the core updates its state and, if the item
//   yields a result, loads the result register, which drives result_valid.
//   One item is taken every cycle while the receiver keeps up; the single
//   input stage and single result register set that rate.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which item_ready drops until result_ready returns.
//   Items that yield no result pass through without waiting on the receiver
//   only when the result register has room.
//   Reset clears both valid flags and returns the core to sync search.
module ofdm_packet_deframer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ofdmdf_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ofdmdf_pkg::out_item_t result
);

    logic                  stage_valid_reg;
    ofdmdf_pkg::in_item_t  stage_item_reg;
    logic                  space;
    logic                  advance;
    logic                  core_valid;
    ofdmdf_pkg::out_item_t core_res;

    assign advance    = stage_valid_reg && space;
    assign item_ready = !stage_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            stage_item_reg <= item;
    end

    ofdmdf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_item_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    ofdmdf_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .load_valid   (core_valid),
        .load_item    (core_res),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> item_ready)
        else $error("item_ready low with empty input register");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && result_valid && !result_ready |-> !item_ready)
        else $error("input taken while both stages are held");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.header_error |->
            !result.last && !result.empty_packet && result.packet_length == '0)
        else $error("header error result carries packet fields");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.empty_packet |-> result.last && result.packet_length == '0)
        else $error("empty marker without last or with length");

endmodule
